// ----- rtl/irs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irs_pkg
// Types and codes shared by the I2C register access sequencer: poll and result
// beat layouts, bus action codes, request kinds, finish codes, phase encoding.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_TX     = 3'd2,
    ACT_RSTART = 3'd3,
    ACT_RCEN   = 3'd4,
    ACT_NACK   = 3'd5,
    ACT_STOP   = 3'd6
  } action_t;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_OK   = 2'd1;
  localparam logic [1:0] FIN_ERR  = 2'd2;

  typedef enum logic [16:0] {
    PH_IDLE       = 17'h00001,
    PH_START      = 17'h00002,
    PH_ADDR_W     = 17'h00004,
    PH_ADDR_ACK   = 17'h00008,
    PH_REG_ACK    = 17'h00010,
    PH_RSTART     = 17'h00020,
    PH_ADDR_R     = 17'h00040,
    PH_ADDR_R_ACK = 17'h00080,
    PH_RCEN       = 17'h00100,
    PH_RX_WAIT    = 17'h00200,
    PH_NACK_WAIT  = 17'h00400,
    PH_STOP       = 17'h00800,
    PH_STOP_WAIT  = 17'h01000,
    PH_ERR_STOP   = 17'h02000,
    PH_ERR_WAIT   = 17'h04000,
    PH_RETRY_STOP = 17'h08000,
    PH_RETRY_WAIT = 17'h10000
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       event_done;
    logic       nack;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       busy_res;
    logic [1:0] finish_status;
    logic [7:0] read_data;
    logic       read_valid;
  } out_beat_t;

endpackage

// ----- rtl/irs_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irs_seq
// Transaction state of the sequencer: phase, held request, retry count,
// latched bus event and captured read byte. Computes the result of one poll
// and advances the state when the poll beat is taken.
// ----------------------------------------------------------------------------
module irs_seq import irs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_beat_t   poll,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output out_beat_t  res
);

  phase_t     phase_r,   phase_nxt;
  logic [1:0] kind_r,    kind_nxt;
  logic [6:0] dev_r,     dev_nxt;
  logic [7:0] reg_r,     reg_nxt;
  logic [7:0] data_r,    data_nxt;
  logic [3:0] retry_r,   retry_nxt;
  logic       done_r,    done_nxt;
  logic [7:0] capt_r,    capt_nxt;
  logic [3:0] limit_r;

  always_comb begin
    logic    take_req;
    action_t act;
    logic [7:0] tx;
    logic [1:0] fin;
    logic    rv;

    take_req = (kind_r == KIND_NONE) &&
               ((poll.mode == KIND_WRITE) || (poll.mode == KIND_READ));
    kind_nxt = take_req ? poll.mode        : kind_r;
    dev_nxt  = take_req ? poll.device_addr : dev_r;
    reg_nxt  = take_req ? poll.reg_addr    : reg_r;
    data_nxt = take_req ? poll.write_data  : data_r;
    done_nxt = done_r | poll.event_done;
    retry_nxt = retry_r;
    capt_nxt  = capt_r;
    phase_nxt = phase_r;
    act = ACT_NONE;
    tx  = 8'h00;
    fin = FIN_NONE;
    rv  = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (kind_nxt != KIND_NONE) phase_nxt = PH_START;
      end
      PH_START: begin
        act = ACT_START;
        phase_nxt = PH_ADDR_W;
      end
      PH_ADDR_W: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          act = ACT_TX;
          tx = {dev_nxt, 1'b0};
          phase_nxt = PH_ADDR_ACK;
        end
      end
      PH_ADDR_ACK: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          if (poll.nack) begin
            phase_nxt = (retry_r < limit_r) ? PH_RETRY_STOP : PH_ERR_STOP;
          end else begin
            retry_nxt = 4'd0;
            act = ACT_TX;
            tx = reg_nxt;
            phase_nxt = PH_REG_ACK;
          end
        end
      end
      PH_REG_ACK: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          if (poll.nack) begin
            phase_nxt = PH_ERR_STOP;
          end else if (kind_nxt == KIND_READ) begin
            phase_nxt = PH_RSTART;
          end else begin
            act = ACT_TX;
            tx = data_nxt;
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_RSTART: begin
        act = ACT_RSTART;
        phase_nxt = PH_ADDR_R;
      end
      PH_ADDR_R: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          act = ACT_TX;
          tx = {dev_nxt, 1'b1};
          phase_nxt = PH_ADDR_R_ACK;
        end
      end
      PH_ADDR_R_ACK: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          phase_nxt = poll.nack ? PH_ERR_STOP : PH_RCEN;
        end
      end
      PH_RCEN: begin
        act = ACT_RCEN;
        phase_nxt = PH_RX_WAIT;
      end
      PH_RX_WAIT: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          capt_nxt = poll.rx_byte;
          rv = 1'b1;
          act = ACT_NACK;
          phase_nxt = PH_NACK_WAIT;
        end
      end
      PH_NACK_WAIT: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          phase_nxt = PH_STOP;
        end
      end
      PH_STOP: begin
        act = ACT_STOP;
        phase_nxt = PH_STOP_WAIT;
      end
      PH_STOP_WAIT: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          phase_nxt = PH_IDLE;
          kind_nxt = KIND_NONE;
          fin = FIN_OK;
        end
      end
      PH_ERR_STOP: begin
        act = ACT_STOP;
        phase_nxt = PH_ERR_WAIT;
      end
      PH_ERR_WAIT: begin
        if (done_nxt) begin
          done_nxt = 1'b0;
          phase_nxt = PH_IDLE;
          retry_nxt = 4'd0;
          kind_nxt = KIND_NONE;
          fin = FIN_ERR;
        end
      end
      PH_RETRY_STOP: begin
        act = ACT_STOP;
        phase_nxt = PH_RETRY_WAIT;
        retry_nxt = retry_r + 4'd1;
      end
      PH_RETRY_WAIT: begin
        // restart from idle with the held request on the next poll
        if (done_nxt) begin
          done_nxt = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    res.action        = act;
    res.tx_byte       = tx;
    res.busy_res      = (kind_nxt != KIND_NONE);
    res.finish_status = fin;
    res.read_data     = capt_nxt;
    res.read_valid    = rv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= KIND_NONE;
      dev_r   <= 7'd0;
      reg_r   <= 8'd0;
      data_r  <= 8'd0;
      retry_r <= 4'd0;
      done_r  <= 1'b0;
      capt_r  <= 8'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      data_r  <= data_nxt;
      retry_r <= retry_nxt;
      done_r  <= done_nxt;
      capt_r  <= capt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

endmodule

// ----- rtl/i2c_register_access_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Steps one I2C single-register write or read over a byte-level bus engine,
// one phase per poll beat, with address-NACK retry and error stop.
// ----------------------------------------------------------------------------
// Output: the result beat of a poll is in the output register in the cycle
//   after the poll is taken.
// Throughput: one poll per clock; the poll side stalls only while a result
//   waits in the output register and the result side stalls.
// Reset (rst_n low, synchronous): idle phase, no request held, retry limit 3,
//   output register empty.
module i2c_register_access_sequencer import irs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;
  out_beat_t step_res;
  logic      in_take;

  // take a poll whenever the output register is empty or drains this cycle
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  irs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_take),
    .poll        (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("poll stalled with empty output register");

  a_read_with_nack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.read_valid) |-> (out_data_r.action == ACT_NACK))
    else $error("read byte captured without NACK action");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.action != ACT_TX)) |-> (out_data_r.tx_byte == 8'h00))
    else $error("tx byte set on non-transmit beat");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.finish_status != FIN_NONE)) |->
      (!out_data_r.busy_res && (out_data_r.action == ACT_NONE)))
    else $error("finish reported while busy or acting");

endmodule

// ----- verif/i2c_register_access_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_test
// Drives poll beats into the register access sequencer and checks every result
// beat against a cycle-free phase model or a fixed beat from the walk. A short
// directed walk covers retry, retry exhaustion and a full read. Random polls
// follow under several retry limits. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_test;
  import irs_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic CHECK_FIXED = 1'b1;
  localparam logic CHECK_PRED  = 1'b0;

  typedef enum {
    ST_IDLE, ST_START, ST_ADDR_W, ST_ADDR_ACK, ST_REG_ACK, ST_RSTART, ST_ADDR_R,
    ST_ADDR_R_ACK, ST_RCEN, ST_RX_WAIT, ST_NACK_WAIT, ST_STOP, ST_STOP_WAIT,
    ST_ERR_STOP, ST_ERR_WAIT, ST_RETRY_STOP, ST_RETRY_WAIT
  } bus_phase_t;

  typedef struct packed {
    in_beat_t  poll;
    logic      fixed;
    out_beat_t res;
  } poll_row_t;

  // Retry limit is 1 during this walk: one address retry, then exhaustion.
  localparam poll_row_t POLL_ROWS [26] = '{
    // idle, reserved mode with extreme operands
    '{'{MODE_RESERVED, 7'h7F, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'hFF}, CHECK_FIXED,
      '{ACT_NONE, 8'h00, 1'b0, FIN_NONE, 8'h00, 1'b0}},
    // write request with an event arriving while idle
    '{'{KIND_WRITE, 7'h7F, 8'hFF, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_FIXED,
      '{ACT_NONE, 8'h00, 1'b1, FIN_NONE, 8'h00, 1'b0}},
    // request while busy is dropped
    '{'{KIND_READ, 7'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00}, CHECK_FIXED,
      '{ACT_START, 8'h00, 1'b1, FIN_NONE, 8'h00, 1'b0}},
    // stale event lets the address go out
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_FIXED,
      '{ACT_TX, 8'hFE, 1'b1, FIN_NONE, 8'h00, 1'b0}},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    // retries exhausted
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_FIXED,
      '{ACT_NONE, 8'h00, 1'b0, FIN_ERR, 8'h00, 1'b0}},
    // full read to device 0, register 0
    '{'{KIND_READ, 7'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'hFF}, CHECK_FIXED,
      '{ACT_NACK, 8'h00, 1'b1, FIN_NONE, 8'hFF, 1'b1}},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00}, CHECK_PRED, '0},
    '{'{KIND_NONE, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00}, CHECK_FIXED,
      '{ACT_NONE, 8'h00, 1'b0, FIN_OK, 8'hFF, 1'b0}}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  // model state
  bus_phase_t bus_phase = ST_IDLE;
  logic [1:0] held_kind = KIND_NONE;
  logic [6:0] held_dev = '0;
  logic [7:0] held_reg = '0;
  logic [7:0] held_wdata = '0;
  logic [3:0] retries_used = '0;
  logic [3:0] retry_allowed = RETRY_LIMIT_RST;
  logic       event_pending = 1'b0;
  logic [7:0] captured = '0;

  out_beat_t   predicted_actions [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        no_gaps = 1'b0;

  i2c_register_access_sequencer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic take_event();
    if (event_pending) begin
      event_pending = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the transaction by one poll and return the result beat it gives.
  function automatic out_beat_t step_register_access(input in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.event_done) event_pending = 1'b1;
    if (held_kind == KIND_NONE && (b.mode == KIND_WRITE || b.mode == KIND_READ)) begin
      held_kind = b.mode;
      held_dev = b.device_addr;
      held_reg = b.reg_addr;
      held_wdata = b.write_data;
    end
    case (bus_phase)
      ST_IDLE: begin
        if (held_kind != KIND_NONE) bus_phase = ST_START;
      end
      ST_START: begin
        r.action = ACT_START;
        bus_phase = ST_ADDR_W;
      end
      ST_ADDR_W: begin
        if (take_event()) begin
          r.action = ACT_TX;
          r.tx_byte = {held_dev, 1'b0};
          bus_phase = ST_ADDR_ACK;
        end
      end
      ST_ADDR_ACK: begin
        if (take_event()) begin
          if (b.nack) begin
            bus_phase = (retries_used < retry_allowed) ? ST_RETRY_STOP : ST_ERR_STOP;
          end else begin
            retries_used = '0;
            r.action = ACT_TX;
            r.tx_byte = held_reg;
            bus_phase = ST_REG_ACK;
          end
        end
      end
      ST_REG_ACK: begin
        if (take_event()) begin
          if (b.nack) begin
            bus_phase = ST_ERR_STOP;
          end else if (held_kind == KIND_READ) begin
            bus_phase = ST_RSTART;
          end else begin
            r.action = ACT_TX;
            r.tx_byte = held_wdata;
            bus_phase = ST_STOP;
          end
        end
      end
      ST_RSTART: begin
        r.action = ACT_RSTART;
        bus_phase = ST_ADDR_R;
      end
      ST_ADDR_R: begin
        if (take_event()) begin
          r.action = ACT_TX;
          r.tx_byte = {held_dev, 1'b1};
          bus_phase = ST_ADDR_R_ACK;
        end
      end
      ST_ADDR_R_ACK: begin
        if (take_event()) bus_phase = b.nack ? ST_ERR_STOP : ST_RCEN;
      end
      ST_RCEN: begin
        r.action = ACT_RCEN;
        bus_phase = ST_RX_WAIT;
      end
      ST_RX_WAIT: begin
        if (take_event()) begin
          captured = b.rx_byte;
          r.read_valid = 1'b1;
          r.action = ACT_NACK;
          bus_phase = ST_NACK_WAIT;
        end
      end
      ST_NACK_WAIT: begin
        if (take_event()) bus_phase = ST_STOP;
      end
      ST_STOP: begin
        r.action = ACT_STOP;
        bus_phase = ST_STOP_WAIT;
      end
      ST_STOP_WAIT: begin
        if (take_event()) begin
          bus_phase = ST_IDLE;
          held_kind = KIND_NONE;
          r.finish_status = FIN_OK;
        end
      end
      ST_ERR_STOP: begin
        r.action = ACT_STOP;
        bus_phase = ST_ERR_WAIT;
      end
      ST_ERR_WAIT: begin
        if (take_event()) begin
          bus_phase = ST_IDLE;
          retries_used = '0;
          held_kind = KIND_NONE;
          r.finish_status = FIN_ERR;
        end
      end
      ST_RETRY_STOP: begin
        r.action = ACT_STOP;
        retries_used = retries_used + 4'd1;
        bus_phase = ST_RETRY_WAIT;
      end
      ST_RETRY_WAIT: begin
        if (take_event()) bus_phase = ST_IDLE;
      end
    endcase
    r.busy_res = (held_kind != KIND_NONE);
    r.read_data = captured;
    return r;
  endfunction

  // Mostly requests when idle; while busy the mode is noise that must be ignored.
  function automatic in_beat_t random_poll(input int unsigned nack_pct);
    in_beat_t    b;
    int unsigned pick;
    b.device_addr = 7'($urandom_range(127));
    b.reg_addr = 8'($urandom_range(255));
    b.write_data = 8'($urandom_range(255));
    b.rx_byte = 8'($urandom_range(255));
    b.event_done = ($urandom_range(99) < 65);
    b.nack = ($urandom_range(99) < nack_pct);
    pick = $urandom_range(99);
    if (held_kind == KIND_NONE) begin
      if (pick < 40) b.mode = KIND_WRITE;
      else if (pick < 80) b.mode = KIND_READ;
      else if (pick < 90) b.mode = MODE_RESERVED;
      else b.mode = KIND_NONE;
    end else begin
      b.mode = pick[1:0];
    end
    return b;
  endfunction

  task automatic send_poll(input in_beat_t b, input logic fixed, input out_beat_t given);
    out_beat_t want;
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    // hold the beat until it is taken
    while (in_stall) @(posedge clk);
    want = step_register_access(b);
    predicted_actions.push_back(fixed ? given : want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [3:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    retry_allowed = limit;
  endtask

  task automatic run_random(input int unsigned count, input logic [3:0] limit,
                            input int unsigned nack_pct, input logic calm);
    drain_results();
    write_retry_limit(limit);
    no_gaps = calm;
    repeat (count) send_poll(random_poll(nack_pct), CHECK_PRED, '0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_retry_limit(4'd1);
    for (int i = 0; i < 26; i++) begin
      send_poll(POLL_ROWS[i].poll, POLL_ROWS[i].fixed, POLL_ROWS[i].res);
    end
    run_random(100, 4'd0, 20, 1'b0);
    // heavy address NACK so the longest retry chain runs out now and then
    run_random(100, 4'd15, 95, 1'b0);
    run_random(100, RETRY_LIMIT_RST, 10, 1'b1);
    run_random(100, 4'($urandom_range(15)), 15, 1'b0);
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    logic      moved;
    moved = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (predicted_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        want = predicted_actions.pop_front();
        if (out_data.action !== want.action || out_data.tx_byte !== want.tx_byte ||
            out_data.busy_res !== want.busy_res ||
            out_data.finish_status !== want.finish_status ||
            out_data.read_data !== want.read_data ||
            out_data.read_valid !== want.read_valid) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (exp/act): action %0d/%0d tx %h/%h busy %b/%b",
                     want.action, out_data.action, want.tx_byte, out_data.tx_byte,
                     want.busy_res, out_data.busy_res);
            $display("  finish %0d/%0d read_data %h/%h read_valid %b/%b",
                     want.finish_status, out_data.finish_status, want.read_data,
                     out_data.read_data, want.read_valid, out_data.read_valid);
          end
        end
      end
    end
    out_stall <= !no_gaps && ($urandom_range(99) < 34);
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ----- i2c_register_access_sequencer.f -----
rtl/irs_pkg.sv
rtl/irs_seq.sv
rtl/i2c_register_access_sequencer.sv
verif/i2c_register_access_sequencer_test.sv
